>>> sv/sdscan_pkg.sv
// Shared types, constants and glyph tables for the seven-segment display scanner.
`timescale 1ns / 1ps

package sdscan_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_TEXT  = 3'd2,
    OP_HEX   = 3'd3,
    OP_DEC   = 3'd4
  } op_e;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned NumStages  = 6;

  localparam logic [7:0]  SegDp      = 8'h80;
  localparam logic [7:0]  SegBlank   = 8'h00;
  localparam logic [7:0]  CharDot    = 8'h2E;
  localparam logic [15:0] DecLimit   = 16'd9999;
  localparam logic [3:0]  NibE       = 4'hE;
  localparam logic [2:0]  TextFull   = 3'd4;

  // Reciprocal constants for digit extraction of values up to 9999.
  localparam logic [13:0] RecipThou  = 14'd8389;  // floor(v * 8389 / 2^23) = v / 1000
  localparam logic [5:0]  RecipHund  = 6'd41;     // floor(r * 41 / 2^12) = r / 100, r < 1000
  localparam logic [6:0]  RecipTens  = 7'd103;    // floor(r * 103 / 2^10) = r / 10, r < 100

  // One item moving through the digit pipeline.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  code;
    logic        first;
    logic [15:0] val;
    logic [3:0]  thou;
    logic [3:0]  hund;
    logic [3:0]  tens;
    logic [9:0]  rem;
  } item_t;

  function automatic logic [7:0] nibble_glyph(input logic [3:0] nib);
    logic [7:0] g;
    begin
      case (nib)
        4'h0: g = 8'h3F;
        4'h1: g = 8'h06;
        4'h2: g = 8'h5B;
        4'h3: g = 8'h4F;
        4'h4: g = 8'h66;
        4'h5: g = 8'h6D;
        4'h6: g = 8'h7D;
        4'h7: g = 8'h07;
        4'h8: g = 8'h7F;
        4'h9: g = 8'h6F;
        4'hA: g = 8'h77;
        4'hB: g = 8'h7C;
        4'hC: g = 8'h39;
        4'hD: g = 8'h5E;
        4'hE: g = 8'h79;
        4'hF: g = 8'h71;
        default: g = SegBlank;
      endcase
      return g;
    end
  endfunction

  // ASCII glyphs; anything without a shape shows blank.
  function automatic logic [7:0] char_glyph(input logic [7:0] code);
    logic [7:0] g;
    begin
      case (code)
        8'h2D: g = 8'h40;  // -
        8'h2E: g = SegDp;  // .
        8'h30: g = 8'h3F;
        8'h31: g = 8'h06;
        8'h32: g = 8'h5B;
        8'h33: g = 8'h4F;
        8'h34: g = 8'h66;
        8'h35: g = 8'h6D;
        8'h36: g = 8'h7D;
        8'h37: g = 8'h07;
        8'h38: g = 8'h7F;
        8'h39: g = 8'h6F;
        8'h41: g = 8'h77;  // A
        8'h43: g = 8'h39;  // C
        8'h45: g = 8'h79;  // E
        8'h46: g = 8'h71;  // F
        8'h47: g = 8'h3D;  // G
        8'h48: g = 8'h76;  // H
        8'h49: g = 8'h06;  // I
        8'h4A: g = 8'h0E;  // J
        8'h4C: g = 8'h38;  // L
        8'h4F: g = 8'h3F;  // O
        8'h50: g = 8'h73;  // P
        8'h53: g = 8'h6D;  // S
        8'h55: g = 8'h3E;  // U
        8'h5F: g = 8'h08;  // _
        8'h62: g = 8'h7C;  // b
        8'h63: g = 8'h58;  // c
        8'h64: g = 8'h5E;  // d
        8'h67: g = 8'h6F;  // g
        8'h68: g = 8'h74;  // h
        8'h6E: g = 8'h54;  // n
        8'h6F: g = 8'h5C;  // o
        8'h70: g = 8'h73;  // p
        8'h71: g = 8'h67;  // q
        8'h72: g = 8'h50;  // r
        8'h74: g = 8'h78;  // t
        8'h75: g = 8'h1C;  // u
        8'h79: g = 8'h6E;  // y
        default: g = SegBlank;
      endcase
      return g;
    end
  endfunction

endpackage

>>> sv/seven_segment_display_scanner_top.sv
// Four-digit multiplexed seven-segment scanner: command pipeline, glyph store and pin drive.
`timescale 1ns / 1ps

// Every beat returns one result beat carrying the digit and segment pin levels after that
// beat's operation. The block takes one beat per cycle while results are taken, and each beat
// passes through six stages that split a decimal value into digits by reciprocal multiplies,
// then into the result register behind them, which holds the glyphs, scan index and pin
// levels, which are updated in acceptance order. A stalled result does not stop acceptance
// until all stages are full.
module seven_segment_display_scanner_top
  import sdscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  char_code_i,
  input  logic        first_char_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  digit_enable_n_o,
  output logic [7:0]  segment_n_o
);

  item_t            stg_q [NumStages];
  item_t            stg_d [NumStages];
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   rdy;
  logic             out_vld_q;

  logic [7:0]       glyph_q [NumDigits];
  logic [7:0]       glyph_d [NumDigits];
  logic [1:0]       scan_q, scan_d;
  logic [2:0]       text_pos_q, text_pos_d;
  logic             text_end_q, text_end_d;
  logic [3:0]       digit_pins_q, digit_pins_d;
  logic [7:0]       seg_pins_q, seg_pins_d;

  logic [27:0]      prod_thou;
  logic [13:0]      sub_thou;
  logic [15:0]      prod_hund;
  logic [9:0]       sub_hund;
  logic [16:0]      prod_tens;
  logic [9:0]       sub_tens;
  logic [3:0]       ones;
  logic             upd;
  item_t            it;

  // Per-stage ready: a stage takes a beat when empty or when it hands its own beat on.
  always_comb begin
    rdy[NumStages] = !out_vld_q || out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];
  assign upd        = vld_q[NumStages-1] && rdy[NumStages];
  assign it         = stg_q[NumStages-1];

  assign prod_thou = 28'(stg_q[0].val[13:0]) * 28'(RecipThou);
  assign sub_thou  = stg_q[1].val[13:0] - 14'(14'(stg_q[1].thou) * 14'd1000);
  assign prod_hund = 16'(stg_q[2].rem) * 16'(RecipHund);
  assign sub_hund  = stg_q[3].rem - 10'(10'(stg_q[3].hund) * 10'd100);
  assign prod_tens = 17'(stg_q[4].rem) * 17'(RecipTens);
  assign sub_tens  = it.rem - 10'(10'(it.tens) * 10'd10);
  assign ones      = sub_tens[3:0];

  always_comb begin
    stg_d[0]       = '0;
    stg_d[0].op    = operation_i;
    stg_d[0].code  = char_code_i;
    stg_d[0].first = first_char_i;
    stg_d[0].val   = value_i;

    stg_d[1]       = stg_q[0];
    stg_d[1].thou  = prod_thou[26:23];

    stg_d[2]       = stg_q[1];
    stg_d[2].rem   = sub_thou[9:0];

    stg_d[3]       = stg_q[2];
    stg_d[3].hund  = prod_hund[15:12];

    stg_d[4]       = stg_q[3];
    stg_d[4].rem   = sub_hund;

    stg_d[5]       = stg_q[4];
    stg_d[5].tens  = prod_tens[13:10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (rdy[NumStages]) begin
        out_vld_q <= vld_q[NumStages-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      stg_q[0] <= stg_d[0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Display state update, applied as a beat enters the result register.
  always_comb begin
    logic [2:0] pos;
    logic       ended;
    glyph_d      = glyph_q;
    scan_d       = scan_q;
    text_pos_d   = text_pos_q;
    text_end_d   = text_end_q;
    digit_pins_d = digit_pins_q;
    seg_pins_d   = seg_pins_q;
    pos          = text_pos_q;
    ended        = text_end_q;
    if (upd) begin
      case (it.op)
        OP_TICK: begin
          digit_pins_d = ~(4'b0001 << scan_q);
          seg_pins_d   = ~glyph_q[scan_q];
          scan_d       = scan_q + 2'd1;
        end
        OP_CLEAR: begin
          for (int k = 0; k < NumDigits; k++) begin
            glyph_d[k] = SegBlank;
          end
        end
        OP_TEXT: begin
          if (it.first) begin
            for (int k = 0; k < NumDigits; k++) begin
              glyph_d[k] = SegBlank;
            end
            pos   = '0;
            ended = 1'b0;
          end
          text_pos_d = pos;
          text_end_d = ended;
          if (!ended) begin
            if (pos != 3'd0 && it.code == CharDot) begin
              // Light the point of the digit placed last.
              for (int k = 0; k < NumDigits; k++) begin
                if (2'(k) == pos[1:0] - 2'd1) begin
                  glyph_d[k] = glyph_d[k] | SegDp;
                end
              end
            end else if (pos < TextFull) begin
              for (int k = 0; k < NumDigits; k++) begin
                if (2'(k) == pos[1:0]) begin
                  glyph_d[k] = char_glyph(it.code);
                end
              end
              text_pos_d = pos + 3'd1;
            end else begin
              text_end_d = 1'b1;
            end
          end
        end
        OP_HEX: begin
          glyph_d[0] = nibble_glyph(it.val[15:12]);
          glyph_d[1] = nibble_glyph(it.val[11:8]);
          glyph_d[2] = nibble_glyph(it.val[7:4]);
          glyph_d[3] = nibble_glyph(it.val[3:0]);
        end
        OP_DEC: begin
          if (it.val > DecLimit) begin
            for (int k = 0; k < NumDigits; k++) begin
              glyph_d[k] = nibble_glyph(NibE);
            end
          end else begin
            // Blank leading zeros.
            glyph_d[0] = (it.val >= 16'd1000) ? nibble_glyph(it.thou) : SegBlank;
            glyph_d[1] = (it.val >= 16'd100)  ? nibble_glyph(it.hund) : SegBlank;
            glyph_d[2] = (it.val >= 16'd10)   ? nibble_glyph(it.tens) : SegBlank;
            glyph_d[3] = nibble_glyph(ones);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumDigits; k++) begin
        glyph_q[k] <= SegBlank;
      end
      scan_q       <= '0;
      text_pos_q   <= '0;
      text_end_q   <= 1'b0;
      digit_pins_q <= '1;
      seg_pins_q   <= '1;
    end else begin
      glyph_q      <= glyph_d;
      scan_q       <= scan_d;
      text_pos_q   <= text_pos_d;
      text_end_q   <= text_end_d;
      digit_pins_q <= digit_pins_d;
      seg_pins_q   <= seg_pins_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign digit_enable_n_o = digit_pins_q;
  assign segment_n_o      = seg_pins_q;

  a_one_digit_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(digit_pins_q) >= 3)
    else $error("more than one digit driven");

  a_text_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_pos_q <= TextFull)
    else $error("text position past last digit");

  a_end_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_end_q |-> text_pos_q == TextFull)
    else $error("string ended before four digits placed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with result slot free");

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && it.op == OP_TICK) |=> scan_q == $past(scan_q) + 2'd1)
    else $error("scan index did not advance on tick");

endmodule

>>> sim/tb.sv
// Testbench for the four-digit seven-segment scanner: directed and random command beats against a pin predictor.
`timescale 1ns / 1ps

module tb;
  import sdscan_pkg::*;

  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam int RandomBeats = 1850;
  localparam int LongHoldOff = 200;
  localparam int StuckLimit  = 2000;
  localparam int DrainCycles = 16;

  localparam logic [7:0] SgA  = 8'h01;
  localparam logic [7:0] SgB  = 8'h02;
  localparam logic [7:0] SgC  = 8'h04;
  localparam logic [7:0] SgD  = 8'h08;
  localparam logic [7:0] SgE  = 8'h10;
  localparam logic [7:0] SgF  = 8'h20;
  localparam logic [7:0] SgG  = 8'h40;
  localparam logic [7:0] SgDp = 8'h80;

  typedef struct packed {
    logic [3:0] digits_n;
    logic [7:0] segs_n;
  } pin_levels_t;

  class scanner_scoreboard;
    logic [7:0]  glyph [4];
    logic [1:0]  scan;
    logic [2:0]  text_pos;
    bit          text_done;
    pin_levels_t pins;
    pin_levels_t pins_due [$];
    int          mismatches;

    function new();
      foreach (glyph[k]) glyph[k] = 8'h00;
      scan       = 2'd0;
      text_pos   = 3'd0;
      text_done  = 1'b0;
      pins       = '{digits_n: 4'hF, segs_n: 8'hFF};
      mismatches = 0;
    endfunction

    function logic [7:0] digit_shape(input logic [3:0] nib);
      logic [7:0] s;
      case (nib)
        4'h0: s = SgA | SgB | SgC | SgD | SgE | SgF;
        4'h1: s = SgB | SgC;
        4'h2: s = SgA | SgB | SgD | SgE | SgG;
        4'h3: s = SgA | SgB | SgC | SgD | SgG;
        4'h4: s = SgB | SgC | SgF | SgG;
        4'h5: s = SgA | SgC | SgD | SgF | SgG;
        4'h6: s = SgA | SgC | SgD | SgE | SgF | SgG;
        4'h7: s = SgA | SgB | SgC;
        4'h8: s = SgA | SgB | SgC | SgD | SgE | SgF | SgG;
        4'h9: s = SgA | SgB | SgC | SgD | SgF | SgG;
        4'hA: s = SgA | SgB | SgC | SgE | SgF | SgG;
        4'hB: s = SgC | SgD | SgE | SgF | SgG;
        4'hC: s = SgA | SgD | SgE | SgF;
        4'hD: s = SgB | SgC | SgD | SgE | SgG;
        4'hE: s = SgA | SgD | SgE | SgF | SgG;
        default: s = SgA | SgE | SgF | SgG;
      endcase
      return s;
    endfunction

    function logic [7:0] ascii_shape(input logic [7:0] c);
      logic [7:0] s;
      if (c >= "0" && c <= "9") begin
        s = digit_shape(4'(c - "0"));
      end else begin
        case (c)
          "-": s = SgG;
          ".": s = SgDp;
          "A": s = digit_shape(4'hA);
          "C": s = digit_shape(4'hC);
          "E": s = digit_shape(4'hE);
          "F": s = digit_shape(4'hF);
          "G": s = SgA | SgC | SgD | SgE | SgF;
          "H": s = SgB | SgC | SgE | SgF | SgG;
          "I": s = SgB | SgC;
          "J": s = SgB | SgC | SgD;
          "L": s = SgD | SgE | SgF;
          "O": s = SgA | SgB | SgC | SgD | SgE | SgF;
          "P": s = SgA | SgB | SgE | SgF | SgG;
          "S": s = SgA | SgC | SgD | SgF | SgG;
          "U": s = SgB | SgC | SgD | SgE | SgF;
          "_": s = SgD;
          "b": s = SgC | SgD | SgE | SgF | SgG;
          "c": s = SgD | SgE | SgG;
          "d": s = SgB | SgC | SgD | SgE | SgG;
          "g": s = SgA | SgB | SgC | SgD | SgF | SgG;
          "h": s = SgC | SgE | SgF | SgG;
          "n": s = SgC | SgE | SgG;
          "o": s = SgC | SgD | SgE | SgG;
          "p": s = SgA | SgB | SgE | SgF | SgG;
          "q": s = SgA | SgB | SgC | SgF | SgG;
          "r": s = SgE | SgG;
          "t": s = SgD | SgE | SgF | SgG;
          "u": s = SgC | SgD | SgE;
          "y": s = SgB | SgC | SgD | SgF | SgG;
          default: s = 8'h00;
        endcase
      end
      return s;
    endfunction

    function void take_char(input logic [7:0] code, input logic first);
      if (first) begin
        foreach (glyph[k]) glyph[k] = 8'h00;
        text_pos  = 3'd0;
        text_done = 1'b0;
      end
      if (text_done) return;
      // a dot after a placed digit lights that digit's point and uses no position
      if (text_pos != 3'd0 && code == ".") begin
        glyph[2'(text_pos - 3'd1)] |= SgDp;
      end else if (text_pos < 3'd4) begin
        glyph[text_pos[1:0]] = ascii_shape(code);
        text_pos = text_pos + 3'd1;
      end else begin
        text_done = 1'b1;
      end
    endfunction

    function void show_decimal(input logic [15:0] val);
      int unsigned rest;
      rest = val;
      if (val > DecLimit) begin
        foreach (glyph[k]) glyph[k] = ascii_shape("E");
        return;
      end
      glyph[3] = digit_shape(4'(rest % 10));
      // blank leading positions, keep inner zeros
      for (int k = 2; k >= 0; k--) begin
        rest = rest / 10;
        glyph[k] = (rest != 0) ? digit_shape(4'(rest % 10)) : 8'h00;
      end
    endfunction

    function void take_command(input logic [2:0] op, input logic [7:0] code,
                               input logic first, input logic [15:0] val);
      case (op)
        OP_TICK: begin
          pins.digits_n = ~(4'b0001 << scan);
          pins.segs_n   = ~glyph[scan];
          scan          = scan + 2'd1;
        end
        OP_CLEAR: foreach (glyph[k]) glyph[k] = 8'h00;
        OP_TEXT:  take_char(code, first);
        OP_HEX: begin
          for (int k = 0; k < 4; k++) glyph[k] = digit_shape(val[15 - 4 * k -: 4]);
        end
        OP_DEC:   show_decimal(val);
        default: ;
      endcase
      pins_due.push_back(pins);
    endfunction

    function void check_pins(input logic [3:0] digits_n, input logic [7:0] segs_n);
      pin_levels_t want;
      if (pins_due.size() == 0) begin
        $display("%0t: unexpected result beat: digit_enable_n %h segment_n %h",
                 $time, digits_n, segs_n);
        mismatches++;
        return;
      end
      want = pins_due.pop_front();
      if (digits_n !== want.digits_n) begin
        $display("%0t: digit_enable_n expected %h actual %h", $time, want.digits_n, digits_n);
        mismatches++;
      end
      if (segs_n !== want.segs_n) begin
        $display("%0t: segment_n expected %h actual %h", $time, want.segs_n, segs_n);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [2:0]  operation;
  logic [7:0]  char_code;
  logic        first_char;
  logic [15:0] value;
  logic        out_valid_o;
  logic        out_ready;
  logic [3:0]  digit_enable_n_o;
  logic [7:0]  segment_n_o;

  scanner_scoreboard sb;
  bit no_idle      = 1'b1;
  bit hold_off_req = 1'b0;
  int beats_in     = 0;
  int stuck_cycles = 0;

  seven_segment_display_scanner_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation),
    .char_code_i      (char_code),
    .first_char_i     (first_char),
    .value_i          (value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .digit_enable_n_o (digit_enable_n_o),
    .segment_n_o      (segment_n_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    string shapes;
    int r;
    shapes = "0123456789ACEFGHIJLOPSU_-bcdghnopqrtuyKz{";
    r = $urandom_range(0, 9);
    if (r < 7) return shapes[$urandom_range(0, shapes.len() - 1)];
    if (r < 8) return ".";
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_decimal();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, 9999));
    if (r < 6) return 16'($urandom_range(0, 99));
    if (r < 7) return 16'($urandom_range(9998, 10001));
    return 16'($urandom);
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [7:0] code,
                           input logic first, input logic [15:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    char_code  <= code;
    first_char <= first;
    value      <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic send_text(input logic [7:0] code, input logic first);
    send_beat(OP_TEXT, code, first, 16'($urandom));
  endtask

  // one string with ticks mixed in so the glyphs show up on the pins
  task automatic send_string();
    int len;
    len = $urandom_range(1, 7);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 3) == 0) send_tick();
      send_text(pick_char(), k == 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) begin
      sb.take_command(operation, char_code, first_char, value);
      beats_in++;
    end
    if (rst_ni && out_valid_o && out_ready) sb.check_pins(digit_enable_n_o, segment_n_o);
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("seven_segment_display_scanner_top test failed");
      $finish;
    end
  end

  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // hold off long enough for the pipeline to fill and stall the input
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int pick;
    sb = new();
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    operation  <= OP_TICK;
    char_code  <= 8'h00;
    first_char <= 1'b0;
    value      <= 16'h0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of every operation
    send_beat(OP_TICK, 8'h00, 1'b0, 16'h0000);
    send_beat(OpUnusedHi, 8'hFF, 1'b1, 16'hFFFF);
    send_beat(OP_HEX, 8'h00, 1'b0, 16'hFFFF);
    send_tick();
    send_beat(OP_HEX, 8'hFF, 1'b1, 16'h0000);
    send_tick();
    send_beat(OP_DEC, 8'h00, 1'b0, 16'd9999);
    send_tick();
    send_beat(OP_DEC, 8'h00, 1'b0, 16'd10000);
    send_beat(OP_DEC, 8'h00, 1'b0, 16'hFFFF);
    send_tick();
    send_beat(OP_DEC, 8'h00, 1'b0, 16'd0);
    send_tick();
    // leading dot, points after a digit, cut-off on the fifth digit, ignored tail
    send_text(".", 1'b1);
    send_text("8", 1'b0);
    send_text(".", 1'b0);
    send_text(".", 1'b0);
    send_text("A", 1'b0);
    send_text("b", 1'b0);
    send_text("C", 1'b0);
    send_text("1", 1'b0);
    send_tick();
    // codes past the table and code zero; continue a string after a hex display
    send_text(8'hFF, 1'b1);
    send_text(8'h00, 1'b0);
    send_beat(OP_HEX, 8'h00, 1'b0, 16'h1234);
    send_text("7", 1'b0);
    send_tick();
    send_beat(OP_CLEAR, 8'hFF, 1'b1, 16'hFFFF);
    send_beat(OpUnusedLo, 8'h00, 1'b0, 16'h0000);
    send_tick();

    hold_off_req = 1'b1;
    while (beats_in < RandomBeats) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) hold_off_req = 1'b1;
      repeat ($urandom_range(20, 80)) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) send_tick();
        else if (pick < 60) send_string();
        else if (pick < 72) send_beat(OP_HEX, 8'($urandom), 1'($urandom), 16'($urandom));
        else if (pick < 86) send_beat(OP_DEC, 8'($urandom), 1'($urandom), pick_decimal());
        else if (pick < 90) send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
        else if (pick < 97) send_text(8'($urandom), 1'($urandom));
        else send_beat(3'($urandom_range(OpUnusedLo, OpUnusedHi)), 8'($urandom),
                       1'($urandom), 16'($urandom));
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b1;

    // let the last accepted beat reach the scoreboard before checking the queue
    @(posedge clk_i);
    while (sb.pins_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("seven_segment_display_scanner_top test passed");
    end else begin
      $display("seven_segment_display_scanner_top test failed");
    end
    $finish;
  end

endmodule
